// ----- src/msce_pkg.sv -----
// shared types, widths and register codes of the mimo svd combiner equaliser
package msce_pkg;

    localparam int STREAM_COUNT = 2;
    localparam int NUM_LANES    = 2 * STREAM_COUNT;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int MAG_W    = PROD_W;
    localparam int DIV_BITS = SAMPLE_W - 1;

    // products, sum, magnitude, then one quotient bit per stage
    localparam int LANE_STAGES = 3 + DIV_BITS;
    localparam int PIPE_DEPTH  = LANE_STAGES + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SAMPLE_W-1:0] SAT_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAT_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(16384);
    localparam logic [COEF_W-1:0] COEF_ZERO  = '0;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(16384);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_RX0_S0 = 3'd0,
        REG_COEF_RX1_S0 = 3'd1,
        REG_COEF_RX0_S1 = 3'd2,
        REG_COEF_RX1_S1 = 3'd3,
        REG_GAIN_S0     = 3'd4,
        REG_GAIN_S1     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [STREAM_COUNT-1:0][COEF_W-1:0] coef_rx0;
        logic [STREAM_COUNT-1:0][COEF_W-1:0] coef_rx1;
        logic [STREAM_COUNT-1:0][GAIN_W-1:0] gain;
    } cfg_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef_a;
        logic [COEF_W-1:0] coef_b;
        logic [GAIN_W-1:0] gain;
    } lane_cfg_t;

endpackage

// ----- src/msce_cfg_regs.sv -----
// configuration register file: combiner weights and stream gains
module msce_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [msce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msce_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output msce_pkg::cfg_t                   cfg
);

    msce_pkg::cfg_t cfg_reg;
    msce_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (msce_pkg::cfg_reg_t'(cfg_index))
                msce_pkg::REG_COEF_RX0_S0: cfg_next.coef_rx0[0] = cfg_wdata;
                msce_pkg::REG_COEF_RX1_S0: cfg_next.coef_rx1[0] = cfg_wdata;
                msce_pkg::REG_COEF_RX0_S1: cfg_next.coef_rx0[1] = cfg_wdata;
                msce_pkg::REG_COEF_RX1_S1: cfg_next.coef_rx1[1] = cfg_wdata;
                msce_pkg::REG_GAIN_S0:     cfg_next.gain[0]     = cfg_wdata;
                msce_pkg::REG_GAIN_S1:     cfg_next.gain[1]     = cfg_wdata;
                default:                   cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_rx0[0] <= msce_pkg::COEF_ONE;
            cfg_reg.coef_rx1[0] <= msce_pkg::COEF_ZERO;
            cfg_reg.coef_rx0[1] <= msce_pkg::COEF_ZERO;
            cfg_reg.coef_rx1[1] <= msce_pkg::COEF_ONE;
            cfg_reg.gain[0]     <= msce_pkg::GAIN_UNITY;
            cfg_reg.gain[1]     <= msce_pkg::GAIN_UNITY;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/msce_lane.sv -----
// one lane: two-tap combiner, then a pipelined saturating divide by the gain
module msce_lane (
    input  logic                                 aclk,
    input  msce_pkg::lane_cfg_t                  lane_cfg,
    input  logic [msce_pkg::LANE_STAGES-1:0]     stage_en,
    input  logic [msce_pkg::SAMPLE_W-1:0]        x0,
    input  logic [msce_pkg::SAMPLE_W-1:0]        x1,
    output logic [msce_pkg::SAMPLE_W-1:0]        result
);

    localparam int DB = msce_pkg::DIV_BITS;
    localparam int MW = msce_pkg::MAG_W;

    logic signed [msce_pkg::PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic signed [msce_pkg::PROD_W-1:0] prod_a_next, prod_b_next;
    logic signed [msce_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic        [msce_pkg::SUM_W-1:0]  neg_sum;
    logic        [MW-1:0]               mag_next;
    logic        [MW-1:0]               sat_limit;

    logic [MW-1:0] rem_reg  [0:DB];
    logic [DB-1:0] quot_reg [0:DB];
    logic          neg_reg  [0:DB];
    logic          zero_reg [0:DB];
    logic          sat_reg  [0:DB];

    logic [MW:0]   diff     [1:DB];
    logic          take     [1:DB];

    assign prod_a_next = $signed(lane_cfg.coef_a) * $signed(x0);
    assign prod_b_next = $signed(lane_cfg.coef_b) * $signed(x1);
    assign sum_next    = msce_pkg::SUM_W'(prod_a_reg) + msce_pkg::SUM_W'(prod_b_reg);
    assign neg_sum     = msce_pkg::SUM_W'(0) - sum_reg;
    assign mag_next    = sum_reg[msce_pkg::SUM_W-1] ? neg_sum[MW-1:0] : sum_reg[MW-1:0];
    // quotient at or above 2^15 saturates either way
    assign sat_limit   = MW'(lane_cfg.gain) << DB;

    always_comb begin
        for (int j = 1; j <= DB; j++) begin
            diff[j] = {1'b0, rem_reg[j-1]} - {1'b0, MW'(lane_cfg.gain) << (DB - j)};
            take[j] = !diff[j][MW];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (stage_en[1]) begin
            sum_reg <= sum_next;
        end
        if (stage_en[2]) begin
            rem_reg[0]  <= mag_next;
            quot_reg[0] <= '0;
            neg_reg[0]  <= sum_reg[msce_pkg::SUM_W-1];
            zero_reg[0] <= (sum_reg == '0);
            sat_reg[0]  <= (mag_next >= sat_limit);
        end
        for (int j = 1; j <= DB; j++) begin
            if (stage_en[2+j]) begin
                rem_reg[j]  <= take[j] ? diff[j][MW-1:0] : rem_reg[j-1];
                quot_reg[j] <= quot_reg[j-1] | (DB'(take[j]) << (DB - j));
                neg_reg[j]  <= neg_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                sat_reg[j]  <= sat_reg[j-1];
            end
        end
    end

    always_comb begin
        if (zero_reg[DB]) begin
            result = '0;
        end else if (sat_reg[DB]) begin
            result = neg_reg[DB] ? msce_pkg::SAT_NEG : msce_pkg::SAT_POS;
        end else if (neg_reg[DB]) begin
            result = msce_pkg::SAMPLE_W'(0) - {1'b0, quot_reg[DB]};
        end else begin
            result = {1'b0, quot_reg[DB]};
        end
    end

endmodule

// ----- src/mimo_svd_combiner_equalizer.sv -----
// top level: 2x2 svd receive combiner with per-stream saturating equaliser
//
// Input channel s_*: one vector of two complex antenna samples per item,
// with a last_sample mark. Output channel m_*: the two equalised streams,
// the zero-gain flag and the copied mark, one result item per input item.
// Both channels are valid/ready; the config port is a plain write port
// (cfg_we, cfg_index, cfg_wdata), to be written only while no item is in
// flight.
// Four lanes (stream 0/1, real/imaginary) run side by side: multiply,
// sum, magnitude, then a 15-stage divider that retires one quotient bit
// per stage; the output register merges the lanes.
// One item is accepted every cycle while no receiver stall backs up into the
// pipeline, made possible by the one-bit-per-stage divider pipeline.
// On a receiver stall the output register holds; each pipeline stage
// still fills while it has a bubble ahead, so input is accepted until
// all 19 slots hold items.
// Reset empties the pipeline and loads identity weights and unity gains.
module mimo_svd_combiner_equalizer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [msce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msce_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [msce_pkg::SAMPLE_W-1:0]     s_rx0_re,
    input  logic [msce_pkg::SAMPLE_W-1:0]     s_rx0_im,
    input  logic [msce_pkg::SAMPLE_W-1:0]     s_rx1_re,
    input  logic [msce_pkg::SAMPLE_W-1:0]     s_rx1_im,
    input  logic                              s_last_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [msce_pkg::SAMPLE_W-1:0]     m_eq0_re,
    output logic [msce_pkg::SAMPLE_W-1:0]     m_eq0_im,
    output logic [msce_pkg::SAMPLE_W-1:0]     m_eq1_re,
    output logic [msce_pkg::SAMPLE_W-1:0]     m_eq1_im,
    output logic                              m_zero_gain_fault,
    output logic                              m_last_out
);

    localparam int NS = msce_pkg::LANE_STAGES;

    msce_pkg::cfg_t cfg;

    logic [NS-1:0] stage_en;
    logic          out_en;
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] last_reg;
    logic          out_valid_reg;

    logic [msce_pkg::SAMPLE_W-1:0] lane_res [msce_pkg::NUM_LANES];
    logic [msce_pkg::SAMPLE_W-1:0] eq_reg   [msce_pkg::NUM_LANES];
    logic                          fault_reg;
    logic                          last_out_reg;

    msce_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // a stage loads when it is empty or its content moves on
    assign out_en           = !out_valid_reg || m_ready;
    assign stage_en[NS-1]   = !valid_reg[NS-1] || out_en;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end
    assign s_ready = stage_en[0];

    for (genvar i = 0; i < msce_pkg::NUM_LANES; i++) begin : g_lane
        msce_pkg::lane_cfg_t           lane_cfg;
        logic [msce_pkg::SAMPLE_W-1:0] x0, x1;

        assign lane_cfg.coef_a = cfg.coef_rx0[i/2];
        assign lane_cfg.coef_b = cfg.coef_rx1[i/2];
        assign lane_cfg.gain   = cfg.gain[i/2];

        if (i % 2 == 0) begin : g_re
            assign x0 = s_rx0_re;
            assign x1 = s_rx1_re;
        end else begin : g_im
            assign x0 = s_rx0_im;
            assign x1 = s_rx1_im;
        end

        msce_lane u_lane (
            .aclk     (aclk),
            .lane_cfg (lane_cfg),
            .stage_en (stage_en),
            .x0       (x0),
            .x1       (x1),
            .result   (lane_res[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (out_en) begin
                out_valid_reg <= valid_reg[NS-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            last_reg[0] <= s_last_sample;
        end
        for (int k = 1; k < NS; k++) begin
            if (stage_en[k]) begin
                last_reg[k] <= last_reg[k-1];
            end
        end
        if (out_en) begin
            for (int i = 0; i < msce_pkg::NUM_LANES; i++) begin
                eq_reg[i] <= lane_res[i];
            end
            fault_reg    <= (cfg.gain[0] == '0) || (cfg.gain[1] == '0);
            last_out_reg <= last_reg[NS-1];
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_eq0_re          = eq_reg[0];
    assign m_eq0_im          = eq_reg[1];
    assign m_eq1_re          = eq_reg[2];
    assign m_eq1_im          = eq_reg[3];
    assign m_zero_gain_fault = fault_reg;
    assign m_last_out        = last_out_reg;

endmodule

// ----- src/msce_checker.sv -----
// port-level checks of the combiner equaliser and their binding to the top level
module msce_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [msce_pkg::SAMPLE_W-1:0]    m_eq0_re,
    input logic [msce_pkg::SAMPLE_W-1:0]    m_eq0_im,
    input logic [msce_pkg::SAMPLE_W-1:0]    m_eq1_re,
    input logic [msce_pkg::SAMPLE_W-1:0]    m_eq1_im,
    input logic                             m_zero_gain_fault,
    input logic                             m_last_out
);

    localparam int CNT_W = $clog2(msce_pkg::PIPE_DEPTH + 1);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             s_fire, m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_fire && !m_fire) begin
            inflight_next = inflight_reg + CNT_W'(1);
        end else if (m_fire && !s_fire) begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // stalled result item holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_eq0_re, m_eq0_im, m_eq1_re,
            m_eq1_im, m_zero_gain_fault, m_last_out}))
        else $error("result item changed while stalled");

    // no result item without an item in flight
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != '0)
        else $error("result item with nothing in flight");

    // empty output register never blocks the input
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with output empty");

    // occupancy within pipeline depth
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= CNT_W'(msce_pkg::PIPE_DEPTH))
        else $error("more items in flight than pipeline slots");

endmodule

bind mimo_svd_combiner_equalizer msce_checker u_msce_checker (.*);
